@@ src/wspf_pkg.sv @@
// Package for the window stack / pointer / focus controller.
// Holds widths, operation codes, constants and the queue entry type.
package wspf_pkg;
  localparam int NSLOT = 8;
  localparam int SW = 3;
  localparam logic [3:0] NO_SLOT = 4'd8;
  localparam logic [2:0] OP_PLACE = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MOVEX = 3'd2;
  localparam logic [2:0] OP_MOVEY = 3'd3;
  localparam logic [2:0] OP_PRESS = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;
  localparam logic [2:0] OP_SYNC = 3'd6;
  localparam logic [2:0] OP_KEY = 3'd7;
  localparam logic [9:0] KEY_ALT = 10'd56;
  localparam logic [9:0] KEY_TAB = 10'd15;
  localparam logic [11:0] MIN_SIZE = 12'd16;
  localparam logic [15:0] TITLE_BAR = 16'd20;
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_KEY = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [3:0] CFG_WIDTH = 4'd0;
  localparam logic [3:0] CFG_HEIGHT = 4'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] delta;
    logic [9:0]  key_code;
    logic [1:0]  key_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  target_slot;
    logic [9:0]  fwd_key_code;
    logic [1:0]  fwd_key_value;
    logic [3:0]  focus_slot;
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
    logic [3:0]  window_count;
    logic        drag_active;
  } res_t;

  // Queue status travelling from the front to the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;
endpackage

@@ src/wspf_if.sv @@
// Valid/ready channel interface carrying one payload per beat.
// Depends on nothing but the payload type parameter.
interface wspf_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/window_stack_pointer_focus.sv @@
// Window stack, pointer and focus controller, top level.
// Moves, release, sync and keys pass through the scan and done states to a result;
// place, remove and Alt+Tab also walk the stack, one entry per cycle, in the shift state;
// a press scans close boxes, then bodies, then shifts the window that was hit.
// The back part runs one beat at a time; a two-entry queue takes new beats meanwhile.
// Synchronous active-low reset empties the stack.
module window_stack_pointer_focus import wspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wspf_if.sink        in_ch,
  wspf_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  // Screen size registers; clamping of odd values happens where they are used.
  logic [12:0] scr_w_r, scr_h_r;
  qhead_t      head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 13'd1280;
      scr_h_r <= 13'd800;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) scr_w_r <= cfg_data;
      else if (cfg_index == CFG_HEIGHT) scr_h_r <= cfg_data;
    end
  end

  // The front part queues incoming beats so the sender is not held by a long press.
  wspf_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .head(head), .pop(pop)
  );

  // The back part runs the item and holds the result until it is taken.
  wspf_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .scr_w(scr_w_r), .scr_h(scr_h_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  // A result beat always reports a count within the slot range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.window_count <= 4'(NSLOT)) else $error("count range");
  // A result beat without an event names no target slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.event_res == EV_NONE |-> out_ch.data.target_slot == 3'd0)
    else $error("target without event");
endmodule

@@ src/wspf_front.sv @@
// Front part: accepts input beats and holds them in a two-entry queue.
// Depends on wspf_pkg.
module wspf_front import wspf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_data,
  output qhead_t head,
  input  logic   pop
);
  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ src/wspf_back.sv @@
// Back part: executes one queued item over several cycles and registers the result.
// Depends on wspf_pkg.
module wspf_back import wspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  qhead_t      head,
  output logic        pop,
  input  logic [12:0] scr_w,
  input  logic [12:0] scr_h,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]  st_r, st_nxt;
  item_t       it_r;
  logic [2:0]  order_r [NSLOT];
  logic [3:0]  count_r, focus_r, drag_r;
  logic [NSLOT-1:0] valid_r;
  logic [15:0] left_r [NSLOT];
  logic [15:0] top_r [NSLOT];
  logic [11:0] wid_r [NSLOT];
  logic [11:0] hgt_r [NSLOT];
  logic [11:0] px_r, py_r;
  logic        alt_r;
  logic [15:0] offx_r, offy_r;
  // scan state
  logic [3:0]  zi_r;      // stack index being scanned, counts down
  logic        pass_r;    // 0 close-box pass, 1 body pass
  logic [2:0]  tgt_r;     // slot to drop or raise
  logic        drop_r;    // shift phase removes (1) or raises (0)
  logic [3:0]  at_r;      // position during shift
  logic        closed_r;
  logic        outv_r;
  res_t        res_r;

  logic [2:0]  s;
  logic signed [17:0] l, t, r, mx, my;
  logic        close_hit, body_hit;
  logic [12:0] lim;
  logic signed [17:0] cv;
  logic [11:0] clamped;
  logic        ex_free;

  assign pop = head.valid && (st_r == ST_IDLE) && !outv_r;
  assign out_valid = outv_r;
  assign out_data = res_r;
  assign ex_free = 1'b1;

  // Hit tests on the scanned entry.
  always_comb begin
    s = order_r[zi_r[2:0]];
    l = 18'(signed'(left_r[s]));
    t = 18'(signed'(top_r[s]));
    r = l + 18'(wid_r[s]);
    mx = 18'(px_r);
    my = 18'(py_r);
    close_hit = valid_r[s] && mx >= r - 18'sd16 && mx < r - 18'sd4 &&
                my >= t - 18'sd16 && my < t - 18'sd4;
    body_hit = valid_r[s] && mx >= l && mx < r && my >= t - 18'sd20 &&
               my < t + $signed({6'd0, hgt_r[s]});
  end

  // Pointer clamp on the selected axis.
  always_comb begin
    lim = (it_r.operation == OP_MOVEX) ? scr_w : scr_h;
    if (lim == 13'd0) lim = 13'd1;
    if (lim > 13'd4096) lim = 13'd4096;
    cv = 18'((it_r.operation == OP_MOVEX) ? px_r : py_r) + 18'(signed'(it_r.delta));
    if (cv < 0) clamped = 12'd0;
    else if (cv >= 18'(lim)) clamped = 12'(lim - 13'd1);
    else clamped = cv[11:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (pop) st_nxt = ST_SCAN;
      ST_SCAN, ST_SHIFT, ST_DONE: st_nxt = st_r;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= 4'd0;
      focus_r <= NO_SLOT;
      drag_r <= NO_SLOT;
      valid_r <= '0;
      px_r <= 12'd640;
      py_r <= 12'd400;
      alt_r <= 1'b0;
      offx_r <= 16'd0;
      offy_r <= 16'd0;
      outv_r <= 1'b0;
      for (int i = 0; i < NSLOT; i++) order_r[i] <= 3'd0;
    end else begin
      if (outv_r && out_ready) outv_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (pop) begin
            it_r <= head.item;
            st_r <= st_nxt;
            zi_r <= count_r - 4'd1;
            pass_r <= 1'b0;
            closed_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          case (it_r.operation)
            OP_PLACE: begin
              valid_r[it_r.slot] <= 1'b1;
              left_r[it_r.slot] <= it_r.pos_x;
              top_r[it_r.slot] <= it_r.pos_y + TITLE_BAR;
              wid_r[it_r.slot] <= (it_r.width < MIN_SIZE) ? MIN_SIZE : it_r.width;
              hgt_r[it_r.slot] <= (it_r.height < MIN_SIZE) ? MIN_SIZE : it_r.height;
              tgt_r <= it_r.slot; drop_r <= 1'b0; at_r <= 4'd0; st_r <= ST_SHIFT;
            end
            OP_REMOVE: begin
              valid_r[it_r.slot] <= 1'b0;
              if (drag_r == {1'b0, it_r.slot}) drag_r <= NO_SLOT;
              tgt_r <= it_r.slot; drop_r <= 1'b1; at_r <= 4'd0; st_r <= ST_SHIFT;
            end
            OP_MOVEX: begin
              px_r <= clamped;
              st_r <= ST_DONE;
            end
            OP_MOVEY: begin
              py_r <= clamped;
              st_r <= ST_DONE;
            end
            OP_RELEASE: begin
              drag_r <= NO_SLOT;
              st_r <= ST_DONE;
            end
            OP_SYNC: begin
              if (!drag_r[3] && valid_r[drag_r[2:0]]) begin
                left_r[drag_r[2:0]] <= 16'(px_r) - offx_r;
                top_r[drag_r[2:0]] <= 16'(py_r) - offy_r;
              end
              st_r <= ST_DONE;
            end
            OP_KEY: begin
              if (it_r.key_code == KEY_ALT) begin
                alt_r <= (it_r.key_value != 2'd0);
                st_r <= ST_DONE;
              end else if (it_r.key_code == KEY_TAB && it_r.key_value == 2'd1 && alt_r) begin
                if (count_r >= 4'd2) begin
                  tgt_r <= order_r[0]; drop_r <= 1'b0; at_r <= 4'd0; st_r <= ST_SHIFT;
                end else st_r <= ST_DONE;
              end else begin
                if (!focus_r[3] && valid_r[focus_r[2:0]]) closed_r <= 1'b1;
                st_r <= ST_DONE;
              end
            end
            default: begin
              // Press: one stack entry per cycle, close boxes first, then bodies.
              if (zi_r[3] || count_r == 4'd0) begin
                if (!pass_r) begin
                  pass_r <= 1'b1; zi_r <= count_r - 4'd1;
                end else st_r <= ST_DONE;
              end else if (!pass_r && close_hit) begin
                valid_r[s] <= 1'b0;
                if (drag_r == {1'b0, s}) drag_r <= NO_SLOT;
                tgt_r <= s; drop_r <= 1'b1; at_r <= 4'd0; closed_r <= 1'b1;
                st_r <= ST_SHIFT;
              end else if (pass_r && body_hit) begin
                if (my < t) begin
                  drag_r <= {1'b0, s};
                  offx_r <= 16'(mx - l);
                  offy_r <= 16'(my - t);
                end
                tgt_r <= s; drop_r <= 1'b0; at_r <= 4'd0; st_r <= ST_SHIFT;
              end else zi_r <= zi_r - 4'd1;
            end
          endcase
        end
        ST_SHIFT: begin
          // Walk the stack one entry a cycle; from the target on, pull entries down.
          if (at_r >= count_r) begin
            st_r <= ST_DONE;
            if (!drop_r && count_r != 4'(NSLOT)) begin
              order_r[count_r[2:0]] <= tgt_r;
              count_r <= count_r + 4'd1;
              focus_r <= {1'b0, tgt_r};
            end
          end else if (order_r[at_r[2:0]] == tgt_r) begin
            if (at_r + 4'd1 < count_r) begin
              order_r[at_r[2:0]] <= order_r[at_r[2:0] + 3'd1];
              order_r[at_r[2:0] + 3'd1] <= tgt_r;
              at_r <= at_r + 4'd1;
            end else begin
              st_r <= ST_DONE;
              if (drop_r) begin
                count_r <= count_r - 4'd1;
                focus_r <= (count_r > 4'd1) ? {1'b0, order_r[at_r[2:0] - 3'd1]} : NO_SLOT;
              end else focus_r <= {1'b0, tgt_r};
            end
          end else at_r <= at_r + 4'd1;
        end
        ST_DONE: begin
          if (!outv_r && ex_free) begin
            outv_r <= 1'b1;
            if (closed_r && it_r.operation == OP_KEY) begin
              res_r.event_res <= EV_KEY;
              res_r.target_slot <= focus_r[2:0];
              res_r.fwd_key_code <= it_r.key_code;
              res_r.fwd_key_value <= it_r.key_value;
            end else if (closed_r) begin
              res_r.event_res <= EV_CLOSE;
              res_r.target_slot <= tgt_r;
              res_r.fwd_key_code <= 10'd0;
              res_r.fwd_key_value <= 2'd0;
            end else begin
              res_r.event_res <= EV_NONE;
              res_r.target_slot <= 3'd0;
              res_r.fwd_key_code <= 10'd0;
              res_r.fwd_key_value <= 2'd0;
            end
            res_r.focus_slot <= focus_r;
            res_r.cursor_x <= px_r;
            res_r.cursor_y <= py_r;
            res_r.window_count <= count_r;
            res_r.drag_active <= !drag_r[3];
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
